// ===== src/mi4_pkg.sv =====
// Shared types and constants for the 4x4 matrix inverse block.
package mi4_pkg;

    // Controller states
    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_MINOR = 7'b0000010,
        S_DET   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    // Datapath command group
    typedef struct packed {
        logic       store_we;     // write entry at load slot
        logic       minor_go;     // begin one minor evaluation
        logic [3:0] minor_idx;    // minor being evaluated
        logic       det_go;       // begin determinant term
        logic [1:0] det_col;      // determinant column
        logic       det_clr;      // clear determinant accumulator
        logic       div_go;       // begin one divide
        logic [3:0] out_pos;      // inverse entry position
        logic       emit;         // present result
    } t_cmd;

    // Datapath status group
    typedef struct packed {
        logic done;               // current multistep operation finished
        logic singular;           // determinant is zero
    } t_sts;

    localparam logic signed [63:0] SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -64'sh7FFF_FFFF_FFFF_FFFF;

    // Minor term order: rows a..i selected per term step
    // Term t uses (x,y,z) from the 3x3 grid index 0..8; sign set for t>=3
    function automatic logic [3:0] term_pick(input logic [2:0] t, input logic [1:0] k);
        logic [3:0] r;
        begin
            r = 4'd0;
            case (t)
                3'd0: r = (k == 2'd0) ? 4'd0 : (k == 2'd1) ? 4'd4 : 4'd8;
                3'd1: r = (k == 2'd0) ? 4'd1 : (k == 2'd1) ? 4'd5 : 4'd6;
                3'd2: r = (k == 2'd0) ? 4'd2 : (k == 2'd1) ? 4'd3 : 4'd7;
                3'd3: r = (k == 2'd0) ? 4'd6 : (k == 2'd1) ? 4'd4 : 4'd2;
                3'd4: r = (k == 2'd0) ? 4'd7 : (k == 2'd1) ? 4'd5 : 4'd0;
                3'd5: r = (k == 2'd0) ? 4'd8 : (k == 2'd1) ? 4'd3 : 4'd1;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/mi4_ctrl.sv =====
// Controller sequencing load, minors, determinant and divides.
module mi4_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  mi4_pkg::t_sts   i_sts,
    output mi4_pkg::t_cmd   o_cmd
);

    mi4_pkg::t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_go, n_go;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mi4_pkg::S_LOAD;
            r_cnt   <= 4'd0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_go    <= n_go;
        end
    end

    assign busy = (r_state != mi4_pkg::S_LOAD);

    // Next state and command
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_go    = 1'b0;
        o_cmd   = '0;
        o_cmd.minor_idx = r_cnt;
        o_cmd.det_col   = r_cnt[1:0];
        o_cmd.out_pos   = r_cnt;
        unique case (r_state)
            mi4_pkg::S_LOAD: begin
                if (start) begin
                    o_cmd.store_we = 1'b1;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_state = mi4_pkg::S_MINOR;
                        n_go    = 1'b1;
                    end
                end
            end
            mi4_pkg::S_MINOR: begin
                o_cmd.minor_go = r_go;
                if (i_sts.done && !r_go) begin
                    n_cnt = r_cnt + 4'd1;
                    n_go  = 1'b1;
                    if (r_cnt == 4'd15) begin
                        n_state = mi4_pkg::S_DET;
                        o_cmd.det_clr = 1'b1;
                    end
                end
            end
            mi4_pkg::S_DET: begin
                o_cmd.det_go = r_go;
                if (i_sts.done && !r_go) begin
                    n_cnt = r_cnt + 4'd1;
                    n_go  = 1'b1;
                    if (r_cnt == 4'd3) begin
                        n_state = mi4_pkg::S_CHECK;
                        n_cnt   = 4'd0;
                        n_go    = 1'b0;
                    end
                end
            end
            mi4_pkg::S_CHECK: begin
                if (i_sts.singular) n_state = mi4_pkg::S_EMIT;
                else begin
                    n_state = mi4_pkg::S_DIV;
                    n_go    = 1'b1;
                end
            end
            mi4_pkg::S_DIV: begin
                o_cmd.div_go = r_go;
                if (i_sts.done && !r_go) n_state = mi4_pkg::S_EMIT;
            end
            mi4_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) n_state = mi4_pkg::S_WAIT;
                else if (!i_sts.singular) begin
                    n_state = mi4_pkg::S_DIV;
                    n_go    = 1'b1;
                end
            end
            mi4_pkg::S_WAIT: begin
                n_state = mi4_pkg::S_LOAD;
                n_cnt   = 4'd0;
            end
            default: n_state = mi4_pkg::S_LOAD;
        endcase
    end

endmodule

// ===== src/mi4_dp.sv =====
// Datapath: matrix store, shared multiplier, minor and determinant sums, divider.
module mi4_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic signed [31:0]  i_entry_value,
    input  mi4_pkg::t_cmd       i_cmd,
    output mi4_pkg::t_sts       o_sts,
    output logic signed [31:0]  o_inverse_value,
    output logic [3:0]          o_entry_position,
    output logic                o_singular,
    output logic                o_last_entry,
    output logic                o_valid
);

    logic [31:0]        r_store [16];
    logic [3:0]         r_wptr;
    logic signed [63:0] r_minor [16];
    logic signed [63:0] r_det;

    // Store entries in arrival order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wptr <= 4'd0;
        else if (i_cmd.store_we) begin
            r_store[r_wptr] <= i_entry_value;
            r_wptr          <= r_wptr + 4'd1;
        end
    end

    // ---------------- Shared fixed-point multiplier (4 partial products) ----
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg;
    logic [2:0]   r_mph;          // 0 idle, 1..4 partial products, 5 result
    logic [127:0] r_macc;
    logic         r_mdone;
    logic signed [63:0] r_mres;
    logic         mul_go;
    logic signed [63:0] mul_a, mul_b;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] rnd;
    logic [127:0] shr;
    logic [63:0]  mag;

    localparam logic [63:0] SAT_HI_U = 64'h7FFF_FFFF_FFFF_FFFF;

    function automatic logic [63:0] absv(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    always_comb begin
        pa = 32'd0; pb = 32'd0; pp_sh = '0;
        case (r_mph)
            3'd1: begin pa = r_ma[31:0];  pb = r_mb[31:0];  end
            3'd2: begin pa = r_ma[31:0];  pb = r_mb[63:32]; end
            3'd3: begin pa = r_ma[63:32]; pb = r_mb[31:0];  end
            3'd4: begin pa = r_ma[63:32]; pb = r_mb[63:32]; end
            default: ;
        endcase
        pp = 64'(pa) * 64'(pb);
        case (r_mph)
            3'd1: pp_sh = {64'd0, pp};
            3'd2, 3'd3: pp_sh = {32'd0, pp, 32'd0};
            3'd4: pp_sh = {pp, 64'd0};
            default: pp_sh = '0;
        endcase
        rnd = r_macc + (128'd1 << (FRAC_BITS - 1));
        shr = rnd >> FRAC_BITS;
        mag = (shr[127:63] != '0) ? SAT_HI_U : shr[63:0];
    end

    // Run partial products and round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mph   <= 3'd0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            if (mul_go) begin
                r_ma   <= absv(mul_a);
                r_mb   <= absv(mul_b);
                r_mneg <= mul_a[63] ^ mul_b[63];
                r_macc <= '0;
                r_mph  <= 3'd1;
            end else if (r_mph >= 3'd1 && r_mph <= 3'd4) begin
                r_macc <= r_macc + pp_sh;
                r_mph  <= r_mph + 3'd1;
            end else if (r_mph == 3'd5) begin
                r_mres  <= r_mneg ? -$signed(mag) : $signed(mag);
                r_mdone <= 1'b1;
                r_mph   <= 3'd0;
            end
        end
    end

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = 65'(a) + 65'(b);
            if (s > 65'(mi4_pkg::SAT_HI)) return mi4_pkg::SAT_HI;
            if (s < 65'(mi4_pkg::SAT_LO)) return mi4_pkg::SAT_LO;
            return s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] v);
        return 64'($signed(v));
    endfunction

    // ---------------- Minor / determinant sequencer ----------------
    // phase: 0 idle, 1 wait first product, 2 wait second product, 3 launch first product
    logic [1:0]  r_ph;
    logic [2:0]  r_term;
    logic        r_det_mode;
    logic signed [63:0] r_sum;
    logic [3:0]  r_midx;
    logic [1:0]  r_dcol;
    logic        r_sdone;

    logic [1:0] sr, sc;
    logic [3:0] g_first, g_second, g_third;
    logic signed [63:0] v_x, v_y, v_z;
    logic signed [63:0] term_v;

    function automatic logic [1:0] skip(input logic [1:0] s, input logic [1:0] i);
        return (i >= s) ? i + 2'd1 : i;
    endfunction

    function automatic logic [3:0] addr_of(input logic [3:0] g, input logic [1:0] s_r,
                                           input logic [1:0] s_c);
        logic [1:0] gi, gj, rr, cc;
        begin
            // Split the 3x3 grid index into row and column
            gi = (g >= 4'd6) ? 2'd2 : (g >= 4'd3) ? 2'd1 : 2'd0;
            gj = 2'(g - {1'b0, gi, 1'b0} - {2'b00, gi});
            rr = skip(s_r, gi);
            cc = skip(s_c, gj);
            return {rr, cc};
        end
    endfunction

    always_comb begin
        sr = r_midx[3:2];
        sc = r_midx[1:0];
        g_first  = mi4_pkg::term_pick(r_term, 2'd0);
        g_second = mi4_pkg::term_pick(r_term, 2'd1);
        g_third  = mi4_pkg::term_pick(r_term, 2'd2);
        v_x = sx(r_store[addr_of(g_first,  sr, sc)]);
        v_y = sx(r_store[addr_of(g_second, sr, sc)]);
        v_z = sx(r_store[addr_of(g_third,  sr, sc)]);
        term_v = (r_det_mode ? r_dcol[0] : (r_term >= 3'd3)) ? -r_mres : r_mres;
        mul_go = 1'b0;
        mul_a  = v_x;
        mul_b  = v_y;
        if (i_cmd.minor_go) begin
            mul_go = 1'b0;
        end
        if (r_ph == 2'd3) begin
            mul_go = 1'b1;
            if (r_det_mode) begin
                mul_a = sx(r_store[{2'd0, r_dcol}]);
                mul_b = r_minor[{2'd0, r_dcol}];
            end
        end else if (r_ph == 2'd1 && r_mdone) begin
            mul_go = 1'b1;
            mul_a  = r_mres;
            mul_b  = v_z;
        end
    end

    // Walk six terms per minor; one product per determinant column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= 2'd0;
            r_sdone <= 1'b0;
            r_det   <= 64'sd0;
        end else begin
            r_sdone <= 1'b0;
            if (i_cmd.det_clr) r_det <= 64'sd0;
            if (i_cmd.minor_go) begin
                r_midx     <= i_cmd.minor_idx;
                r_term     <= 3'd0;
                r_sum      <= 64'sd0;
                r_det_mode <= 1'b0;
                r_ph       <= 2'd3;
            end else if (i_cmd.det_go) begin
                r_dcol     <= i_cmd.det_col;
                r_det_mode <= 1'b1;
                r_ph       <= 2'd3;
            end else if (r_ph == 2'd3) begin
                r_ph <= r_det_mode ? 2'd2 : 2'd1;
            end else if (r_ph == 2'd1 && r_mdone) begin
                r_ph <= 2'd2;
            end else if (r_ph == 2'd2 && r_mdone) begin
                if (r_det_mode) begin
                    r_det   <= sadd(r_det, term_v);
                    r_ph    <= 2'd0;
                    r_sdone <= 1'b1;
                end else if (r_term == 3'd5) begin
                    r_minor[r_midx] <= sadd(r_sum, term_v);
                    r_ph    <= 2'd0;
                    r_sdone <= 1'b1;
                end else begin
                    r_sum  <= sadd(r_sum, term_v);
                    r_term <= r_term + 3'd1;
                    r_ph   <= 2'd3;
                end
            end
        end
    end

    // ---------------- Restoring divider, one quotient bit per cycle ----
    localparam int NB = 64 + FRAC_BITS;
    logic [NB-1:0] r_dnum;
    logic [64:0]   r_rem;
    logic [39:0]   r_q;
    logic [63:0]   r_dden;
    logic          r_dneg;
    logic [6:0]    r_dcnt;
    logic          r_dbusy, r_ddone;
    logic [31:0]   r_qout;
    logic signed [63:0] cof;
    logic [64:0]   rem_sh;
    logic [40:0]   q_sh;
    logic [40:0]   q_fin;

    always_comb begin
        cof = r_minor[{i_cmd.out_pos[1:0], i_cmd.out_pos[3:2]}];
        if (i_cmd.out_pos[0] ^ i_cmd.out_pos[2]) cof = -cof;
        rem_sh = {r_rem[63:0], r_dnum[NB-1]};
        q_sh   = {r_q, 1'b0};
        q_fin  = {1'b0, r_q} + ((r_rem[63:0] >= r_dden - r_rem[63:0]) ? 41'd1 : 41'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_go) begin
                r_dnum  <= {absv(cof), {FRAC_BITS{1'b0}}};
                r_dden  <= absv(r_det);
                r_dneg  <= cof[63] ^ r_det[63];
                r_rem   <= '0;
                r_q     <= '0;
                r_dcnt  <= 7'(NB);
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt != 7'd0) begin
                r_dnum <= r_dnum << 1;
                r_dcnt <= r_dcnt - 7'd1;
                if (rem_sh >= {1'b0, r_dden}) begin
                    r_rem <= rem_sh - {1'b0, r_dden};
                    r_q   <= (q_sh[40] || q_sh[39:0] + 40'd1 > 40'hFF_FFFF_FFFF) ?
                             40'hFF_FFFF_FFFF : q_sh[39:0] + 40'd1;
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= q_sh[40] ? 40'hFF_FFFF_FFFF : q_sh[39:0];
                end
            end else if (r_dbusy) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
                if (r_dneg)
                    r_qout <= (q_fin > 41'h8000_0000) ? 32'h8000_0000 : 32'(-q_fin[31:0]);
                else
                    r_qout <= (q_fin > 41'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_fin[31:0];
            end
        end
    end

    // Status and result
    assign o_sts.done     = r_sdone | r_ddone;
    assign o_sts.singular = (r_det == 64'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= i_cmd.emit;
        if (i_cmd.emit) begin
            o_inverse_value  <= o_sts.singular ? 32'sd0 : $signed(r_qout);
            o_entry_position <= i_cmd.out_pos;
            o_singular       <= o_sts.singular;
            o_last_entry     <= (i_cmd.out_pos == 4'd15);
        end
    end

endmodule

// ===== src/matrix4_inverse.sv =====
// Top level of the 4x4 fixed-point matrix inverse.
//  Channel   Direction  Signals                                     Transfer
//  command   in         start, busy, i_entry_value                  start & !busy
//  result    out        o_valid, o_inverse_value, o_entry_position,  o_valid
//                       o_singular, o_last_entry
// Sixteen loads fill the matrix store. The sixteenth starts 16 minors of six three-factor
// terms on the shared four-pass multiplier, four determinant products, then, unless the
// determinant is zero, sixteen restoring divides of 64+FRAC_BITS bit steps each.
// Results leave one per divide, or all zero with no divides when the determinant is zero;
// busy stays high from the sixteenth load to the last result.
// Synchronous active-low reset clears the controller and load count.
// The receiver cannot stall; each result is valid for one cycle.
module matrix4_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_entry_value,
    output logic               o_valid,
    output logic signed [31:0] o_inverse_value,
    output logic [3:0]         o_entry_position,
    output logic               o_singular,
    output logic               o_last_entry
);

    mi4_pkg::t_cmd cmd;
    mi4_pkg::t_sts sts;

    mi4_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sts(sts), .o_cmd(cmd)
    );

    mi4_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_entry_value(i_entry_value),
        .i_cmd(cmd), .o_sts(sts), .o_inverse_value(o_inverse_value),
        .o_entry_position(o_entry_position), .o_singular(o_singular),
        .o_last_entry(o_last_entry), .o_valid(o_valid)
    );

    // Last flag only with the final position
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_entry == (o_entry_position == 4'd15)))
        else $error("last flag mismatch");

    // Busy while results are being produced
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> busy)
        else $error("emit while idle");

    // Singular results carry zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_inverse_value == 32'sd0))
        else $error("nonzero singular entry");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the 4x4 fixed-point matrix inverse: directed and random matrices.
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         pos;
        logic               sing;
        logic               last;
    } t_inv_entry;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_entry_value;
    logic               o_valid;
    logic signed [31:0] o_inverse_value;
    logic [3:0]         o_entry_position;
    logic               o_singular;
    logic               o_last_entry;

    logic signed [31:0] loaded_entries [16];
    int unsigned        load_slot;
    t_inv_entry         inverse_expect [$];
    int unsigned        error_count;
    int unsigned        idle_cycles;

    matrix4_inverse #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_entry_value    (i_entry_value),
        .o_valid          (o_valid),
        .o_inverse_value  (o_inverse_value),
        .o_entry_position (o_entry_position),
        .o_singular       (o_singular),
        .o_last_entry     (o_last_entry)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturating add to the symmetric 64-bit range
    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, mi4_pkg::SAT_HI})) return mi4_pkg::SAT_HI;
        if (s < $signed({1'b1, mi4_pkg::SAT_LO})) return mi4_pkg::SAT_LO;
        return s[63:0];
    endfunction

    // Fixed-point product, rounded half away from zero, saturated
    function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [127:0] p;
        logic [63:0]  ua, ub, m;
        logic         neg;
        neg = a[63] ^ b[63];
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        m = (p > {64'd0, mi4_pkg::SAT_HI}) ? mi4_pkg::SAT_HI : p[63:0];
        return neg ? -m : m;
    endfunction

    // (num << FRAC) / den, rounded half away from zero, saturated to 32 bits
    function automatic logic signed [31:0] fix_div(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
        logic [127:0] n, d, q, r;
        logic         neg;
        neg = num[63] ^ den[63];
        n = {64'd0, (num[63] ? -num : num)} << FRAC;
        d = {64'd0, (den[63] ? -den : den)};
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        if (neg) return (q > 128'h8000_0000) ? Q_MIN : -$signed(q[31:0]);
        return (q > 128'h7FFF_FFFF) ? Q_MAX : q[31:0];
    endfunction

    function automatic logic signed [63:0] entry64(input int r, input int c);
        return 64'(loaded_entries[r * 4 + c]);
    endfunction

    // Determinant of the 3x3 minor left after dropping one row and column
    function automatic logic signed [63:0] minor_det(input int skip_r, input int skip_c);
        logic signed [63:0] g [9];
        logic signed [63:0] s;
        int n;
        n = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (r != skip_r && c != skip_c) begin
                    g[n] = entry64(r, c);
                    n++;
                end
        s = fix_mul(fix_mul(g[0], g[4]), g[8]);
        s = sat_sum(s, fix_mul(fix_mul(g[1], g[5]), g[6]));
        s = sat_sum(s, fix_mul(fix_mul(g[2], g[3]), g[7]));
        s = sat_sum(s, -fix_mul(fix_mul(g[6], g[4]), g[2]));
        s = sat_sum(s, -fix_mul(fix_mul(g[7], g[5]), g[0]));
        s = sat_sum(s, -fix_mul(fix_mul(g[8], g[3]), g[1]));
        return s;
    endfunction

    // Store one entry; on the sixteenth queue the whole inverse
    task automatic record_entry(input logic signed [31:0] v);
        logic signed [63:0] minors [16];
        logic signed [63:0] det, term, cof;
        t_inv_entry e;
        loaded_entries[load_slot] = v;
        if (load_slot != 15) begin
            load_slot++;
            return;
        end
        load_slot = 0;
        for (int k = 0; k < 16; k++) minors[k] = minor_det(k / 4, k % 4);
        det = 0;
        for (int c = 0; c < 4; c++) begin
            term = fix_mul(entry64(0, c), minors[c]);
            det = sat_sum(det, (c % 2) ? -term : term);
        end
        for (int k = 0; k < 16; k++) begin
            e.pos = k[3:0];
            e.sing = (det == 0);
            e.last = (k == 15);
            e.value = 0;
            if (!e.sing) begin
                cof = minors[(k % 4) * 4 + k / 4];
                if (((k / 4) + (k % 4)) % 2) cof = -cof;
                e.value = fix_div(cof, det);
            end
            inverse_expect.push_back(e);
        end
    endtask

    // Transfer one entry after a random gap
    task automatic send_entry(input logic signed [31:0] v);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_entry_value <= v;
        do @(posedge i_clk); while (busy);
        record_entry(v);
    endtask

    task automatic send_matrix(input logic signed [31:0] m [16]);
        for (int k = 0; k < 16; k++) send_entry(m[k]);
    endtask

    task automatic test_extremes();
        logic signed [31:0] m [16];
        m = '{Q_MAX, Q_MIN, 32'sd0, Q_ONE,
              Q_ONE, Q_MAX, Q_MIN, 32'sd0,
              32'sd0, Q_ONE, Q_MAX, Q_MIN,
              Q_MIN, 32'sd0, Q_ONE, 32'sd1};
        send_matrix(m);
    endtask

    // Tiny diagonal: determinant rounds to zero
    task automatic test_singular();
        logic signed [31:0] m [16];
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sd1 : 32'sd0;
        send_matrix(m);
    endtask

    task automatic test_random(input int n_matrices);
        logic signed [31:0] m [16];
        int style;
        for (int j = 0; j < n_matrices; j++) begin
            style = $urandom_range(0, 9);
            for (int k = 0; k < 16; k++) begin
                case ($urandom_range(0, 3))
                    0: m[k] = $urandom;
                    1: m[k] = 32'($urandom_range(0, 2 ** 21 - 1)) - 32'sd1048576;
                    2: m[k] = 32'($urandom_range(0, 2 ** 17 - 1)) - 32'sd65536;
                    default: m[k] = 32'sd0;
                endcase
                // Well-conditioned: small off-diagonal, strong diagonal
                if (style < 6) begin
                    m[k] = 32'($urandom_range(0, 2 ** 18 - 1)) - 32'sd131072;
                    if (k % 5 == 0)
                        m[k] = ($urandom_range(0, 1) ? 32'sd1 : -32'sd1)
                               * (32'sh0008_0000 + 32'($urandom_range(0, 2 ** 19)));
                end
            end
            // Degenerate: repeat a row
            if (style == 9)
                for (int c = 0; c < 4; c++) m[8 + c] = m[c];
            send_matrix(m);
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_inv_entry e;
        if (i_rst_n && o_valid) begin
            if (inverse_expect.size() == 0) begin
                $display("%0t: unexpected result value=%h pos=%0d", $time,
                         o_inverse_value, o_entry_position);
                error_count++;
            end else begin
                e = inverse_expect.pop_front();
                if (o_inverse_value !== e.value || o_entry_position !== e.pos ||
                    o_singular !== e.sing || o_last_entry !== e.last) begin
                    $display("%0t: mismatch expected value=%h pos=%0d sing=%b last=%b",
                             $time, e.value, e.pos, e.sing, e.last);
                    $display("%0t:          actual   value=%h pos=%0d sing=%b last=%b",
                             $time, o_inverse_value, o_entry_position, o_singular,
                             o_last_entry);
                    error_count++;
                end
            end
        end
    end

    // Stop on a long stretch with no transfer in either direction
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_valid)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        load_slot = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_entry_value = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_singular();
        test_random(6);
        start <= 1'b0;
        while (inverse_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mi4_pkg.sv
src/mi4_ctrl.sv
src/mi4_dp.sv
src/matrix4_inverse.sv
test/tb_top.sv
